// ===== rtl/lbtc_pkg.sv =====
// lbtc_pkg: field widths, opcodes and the structs shared by the tag cache
// top level and its slot cells. No dependencies.
`default_nettype none

package lbtc_pkg;

  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 17;
  localparam int STAMP_W = 32;
  localparam int OUT_IDX_W = 4;

  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  // search token walking the row of cells
  typedef struct packed {
    logic               active;
    logic               found;
    logic [STAMP_W-1:0] stamp;
    logic [SIZE_W-1:0]  size;
  } probe_t;

  // update broadcast to the cells at the end of a request
  typedef struct packed {
    logic               touch;
    logic               wr;
    logic [STAMP_W-1:0] stamp;
    logic [SIZE_W-1:0]  size;
  } commit_t;

endpackage

`default_nettype wire

// ===== rtl/lru_block_tag_cache.sv =====
// Fully associative block tag cache with least-recently-used replacement.
// A request is accepted only while the block is idle. A search token then
// walks the row of SLOT_COUNT slot cells, one cell per cycle, looking for a
// matching key (find) or a free or oldest slot (store); the result is
// registered and the winning slot is updated as it is written out. A new
// request is accepted only once the previous result has been written
// out, after the token has walked the whole cell row. A find restamps
// the lowest matching slot; a store larger than SLOT_BYTES changes nothing
// and returns all zeros. The use counter saturates at its maximum.
// Depends on lbtc_pkg and lbtc_cell.
`default_nettype none

module lru_block_tag_cache
  import lbtc_pkg::*;
#(
  parameter int SLOT_COUNT = 16,
  parameter int SLOT_BYTES = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 op,
  input  wire logic [KEY_W-1:0]     key,
  input  wire logic [SIZE_W-1:0]    block_size,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      hit,
  output logic [OUT_IDX_W-1:0]      slot_index,
  output logic [SIZE_W-1:0]         kept_size,
  output logic                      kept
);

  localparam int IDX_W = $clog2(SLOT_COUNT);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic               launch;
  logic               op_q;
  logic [KEY_W-1:0]   key_q;
  logic [SIZE_W-1:0]  size_q;
  logic [STAMP_W-1:0] use_counter;
  logic [STAMP_W-1:0] stamp_next;

  logic               res_hit;
  logic [IDX_W-1:0]   res_idx;
  logic [SIZE_W-1:0]  res_size;
  logic               res_kept;

  probe_t             chain     [SLOT_COUNT+1];
  logic [IDX_W-1:0]   chain_idx [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0] token_map;

  commit_t            commit;
  logic               in_fire;
  logic               finish_fire;
  logic               fits;
  probe_t             last;
  logic [IDX_W+OUT_IDX_W-1:0] idx_ext;

  assign in_ready    = (state == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign finish_fire = (state == S_FINISH) && (!out_valid || out_ready);
  assign last        = chain[SLOT_COUNT];
  assign fits        = 32'(size_q) <= 32'(SLOT_BYTES);
  assign stamp_next  = (use_counter == STAMP_MAX) ? STAMP_MAX : use_counter + 1'b1;

  // token entering the first cell
  assign chain[0].active = launch;
  assign chain[0].found  = 1'b0;
  assign chain[0].stamp  = STAMP_MAX;
  assign chain[0].size   = '0;
  assign chain_idx[0]    = '0;

  assign commit.touch = finish_fire && res_hit;
  assign commit.wr    = finish_fire && res_kept;
  assign commit.stamp = stamp_next;
  assign commit.size  = size_q;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    lbtc_cell #(
      .CELL_INDEX(i),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op_q),
      .key       (key_q),
      .probe_in  (chain[i]),
      .idx_in    (chain_idx[i]),
      .probe_out (chain[i+1]),
      .idx_out   (chain_idx[i+1]),
      .commit    (commit),
      .commit_idx(res_idx)
    );
    assign token_map[i] = chain[i+1].active;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_fire) state_next = S_SEARCH;
      S_SEARCH: if (last.active) state_next = S_FINISH;
      S_FINISH: if (finish_fire) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      launch      <= 1'b0;
      use_counter <= '0;
      out_valid   <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= in_fire;
      if (commit.touch || commit.wr) begin
        use_counter <= stamp_next;
      end
      if (finish_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q   <= op;
      key_q  <= key;
      size_q <= block_size;
    end
    if (state == S_SEARCH && last.active) begin
      if (op_q == OP_FIND) begin
        res_hit  <= last.found;
        res_idx  <= last.found ? chain_idx[SLOT_COUNT] : '0;
        res_size <= last.found ? last.size : '0;
        res_kept <= 1'b0;
      end else begin
        res_hit  <= 1'b0;
        res_idx  <= fits ? chain_idx[SLOT_COUNT] : '0;
        res_size <= fits ? size_q : '0;
        res_kept <= fits;
      end
    end
  end

  assign idx_ext = (IDX_W + OUT_IDX_W)'(res_idx);

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      hit        <= res_hit;
      slot_index <= idx_ext[OUT_IDX_W-1:0];
      kept_size  <= res_size;
      kept       <= res_kept;
    end
  end

  // only one token in flight
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(token_map) <= 1)
    else $error("more than one search token in the cell row");

  a_token_in_search: assert property (@(posedge clk) disable iff (rst)
    last.active |-> state == S_SEARCH)
    else $error("search token left the row outside a search");

  a_commit_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(commit.touch && commit.wr))
    else $error("restamp and store at once");

  a_counter_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> use_counter >= $past(use_counter))
    else $error("use counter went backward");

  a_hit_kept_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && kept))
    else $error("result reports both hit and kept");

endmodule

`default_nettype wire

// ===== rtl/lbtc_cell.sv =====
// lbtc_cell: one cache slot (valid, key, stamp, size) plus one stage of the
// search token chain. Depends on lbtc_pkg.
`default_nettype none

module lbtc_cell
  import lbtc_pkg::*;
#(
  parameter int CELL_INDEX = 0,
  parameter int IDX_W = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              op,
  input  wire logic [KEY_W-1:0]  key,
  input  wire probe_t            probe_in,
  input  wire logic [IDX_W-1:0]  idx_in,
  output probe_t                 probe_out,
  output logic      [IDX_W-1:0]  idx_out,
  input  wire commit_t           commit,
  input  wire logic [IDX_W-1:0]  commit_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic               valid;
  logic [STAMP_W-1:0] stamp;
  logic [KEY_W-1:0]   slot_key;
  logic [SIZE_W-1:0]  slot_size;

  probe_t             probe_next;
  logic [IDX_W-1:0]   idx_next;

  always_comb begin
    probe_next = probe_in;
    idx_next   = idx_in;
    if (probe_in.active && !probe_in.found) begin
      if (op == OP_FIND) begin
        if (valid && slot_key == key) begin
          probe_next.found = 1'b1;
          probe_next.size  = slot_size;
          idx_next         = MY_IDX;
        end
      end else begin
        if (!valid) begin
          // first free slot ends the victim search
          probe_next.found = 1'b1;
          idx_next         = MY_IDX;
        end else if (stamp < probe_in.stamp) begin
          probe_next.stamp = stamp;
          idx_next         = MY_IDX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.active <= 1'b0;
    end else begin
      probe_out.active <= probe_next.active;
    end
    probe_out.found <= probe_next.found;
    probe_out.stamp <= probe_next.stamp;
    probe_out.size  <= probe_next.size;
    idx_out         <= idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      stamp <= '0;
    end else if ((commit.touch || commit.wr) && commit_idx == MY_IDX) begin
      stamp <= commit.stamp;
      if (commit.wr) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit.wr && commit_idx == MY_IDX) begin
      slot_key  <= key;
      slot_size <= commit.size;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_lru_block_tag_cache.sv =====
// Self-checking testbench for lru_block_tag_cache: random and directed find/store
// requests, with a tag store tracker that predicts every response.
// Depends on lbtc_pkg and the lru_block_tag_cache RTL.
`default_nettype none

module tb_lru_block_tag_cache
  import lbtc_pkg::*;
;
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_BYTES = 65536;
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_REQUESTS = 800;
  localparam int POOL_DEPTH = 24;

  typedef struct packed {
    logic                 hit;
    logic [OUT_IDX_W-1:0] slot;
    logic [SIZE_W-1:0]    kept_size;
    logic                 kept;
  } cache_reply_t;

  // mirrors the slot array and queues the response each accepted request should produce
  class lru_tag_tracker;
    bit                 valid_q[SLOT_COUNT];
    logic [KEY_W-1:0]   key_q[SLOT_COUNT];
    logic [STAMP_W-1:0] stamp_q[SLOT_COUNT];
    logic [SIZE_W-1:0]  size_q[SLOT_COUNT];
    logic [STAMP_W-1:0] use_count;
    cache_reply_t       awaited[$];
    int                 mismatches;

    function new();
      use_count  = '0;
      mismatches = 0;
      foreach (valid_q[i]) begin
        valid_q[i] = 1'b0;
        stamp_q[i] = '0;
      end
    endfunction

    // use counter sticks at its maximum
    function logic [STAMP_W-1:0] bump_stamp();
      if (use_count != STAMP_MAX) use_count++;
      return use_count;
    endfunction

    function void note_request(logic o, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] s);
      cache_reply_t r;
      int           victim;
      r = '0;
      if (o == OP_FIND) begin
        // lowest matching slot wins
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!r.hit && valid_q[i] && key_q[i] == k) begin
            stamp_q[i]  = bump_stamp();
            r.hit       = 1'b1;
            r.slot      = OUT_IDX_W'(i);
            r.kept_size = size_q[i];
          end
        end
      end else begin
        // first free slot, else oldest stamp with lowest index on ties
        victim = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!valid_q[i]) begin
            victim = i;
            break;
          end
          if (stamp_q[i] < stamp_q[victim]) victim = i;
        end
        if (s <= SLOT_BYTES) begin
          size_q[victim]  = s;
          key_q[victim]   = k;
          stamp_q[victim] = bump_stamp();
          valid_q[victim] = 1'b1;
          r.slot          = OUT_IDX_W'(victim);
          r.kept_size     = s;
          r.kept          = 1'b1;
        end
      end
      awaited.push_back(r);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_response(logic h, logic [OUT_IDX_W-1:0] idx, logic [SIZE_W-1:0] sz,
                                 logic kp);
      cache_reply_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("response with none pending: hit=%0b slot=%0d size=%0d kept=%0b",
                       h, idx, sz, kp));
        return;
      end
      want = awaited.pop_front();
      if (h !== want.hit || idx !== want.slot || sz !== want.kept_size || kp !== want.kept)
        flag($sformatf({"expected hit=%0b slot=%0d size=%0d kept=%0b, ",
                        "got hit=%0b slot=%0d size=%0d kept=%0b"},
                       want.hit, want.slot, want.kept_size, want.kept, h, idx, sz, kp));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 op = OP_FIND;
  logic [KEY_W-1:0]     key = '0;
  logic [SIZE_W-1:0]    block_size = '0;
  logic                 out_ready = 1'b0;
  wire logic            in_ready;
  wire logic            out_valid;
  wire logic            hit;
  wire logic [OUT_IDX_W-1:0] slot_index;
  wire logic [SIZE_W-1:0]    kept_size;
  wire logic            kept;

  lru_tag_tracker       tracker = new();
  int                   sent_count = 0;
  int                   cycles_quiet = 0;
  bit                   calm_tail = 1'b0;
  logic [KEY_W-1:0]     key_pool[POOL_DEPTH];

  lru_block_tag_cache #(
    .SLOT_COUNT(SLOT_COUNT),
    .SLOT_BYTES(SLOT_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .key(key),
    .block_size(block_size),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(hit),
    .slot_index(slot_index),
    .kept_size(kept_size),
    .kept(kept)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // response checked before the new request is noted: a response leaving on the
  // same edge always belongs to an earlier request
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.check_response(hit, slot_index, kept_size, kept);
      if (in_valid && in_ready) tracker.note_request(op, key, block_size);
      if ((out_valid && out_ready) || (in_valid && in_ready)) cycles_quiet = 0;
      else cycles_quiet = cycles_quiet + 1;
      if (cycles_quiet >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic issue_request(input logic o, input logic [KEY_W-1:0] k,
                               input logic [SIZE_W-1:0] s);
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    key        <= k;
    block_size <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // receiver: random ready bursts, one long hold-off to back the block up
  initial begin : receiver
    bit held_off;
    held_off = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && sent_count >= 300) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0]  k;
    logic [SIZE_W-1:0] s;
    int                pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty cache, extremes of key and size, refused stores, duplicates
    issue_request(OP_FIND, '0, '1);
    issue_request(OP_STORE, '1, 17'd0);
    issue_request(OP_STORE, '0, 17'd65536);
    issue_request(OP_STORE, 64'h8000_0000_0000_0000, 17'd65537);
    issue_request(OP_STORE, 64'h5555_5555_5555_5555, '1);
    issue_request(OP_FIND, '1, 17'd0);
    issue_request(OP_FIND, '0, 17'd0);
    issue_request(OP_STORE, '1, 17'd4);
    issue_request(OP_FIND, '1, 17'd0);
    issue_request(OP_FIND, 64'hAAAA_AAAA_AAAA_AAAA, 17'd0);
    // fill the remaining slots, then force evictions
    for (int i = 3; i < SLOT_COUNT; i++)
      issue_request(OP_STORE, 64'h100 + i, SIZE_W'(i * 4000));
    issue_request(OP_STORE, 64'hDEAD_BEEF_0000_0001, 17'd100);
    issue_request(OP_STORE, 64'hDEAD_BEEF_0000_0002, 17'd200);
    issue_request(OP_FIND, '0, 17'd0);

    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS - 100) calm_tail = 1'b1;
      if ($urandom_range(0, 19) == 0)
        key_pool[$urandom_range(0, POOL_DEPTH - 1)] = {$urandom, $urandom};
      k = key_pool[$urandom_range(0, POOL_DEPTH - 1)];
      if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 55) begin
        issue_request(OP_FIND, k, SIZE_W'($urandom_range(0, 131071)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8) s = SIZE_W'($urandom_range(65537, 131071));
        else if (pick < 14) s = 17'd65536;
        else if (pick < 18) s = 17'd0;
        else s = SIZE_W'($urandom_range(0, 65536));
        issue_request(OP_STORE, k, s);
      end
    end
    in_valid <= 1'b0;

    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (SLOT_COUNT + 8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
